// ----- design/dss_pkg.sv -----
// ----------------------------------------------------------------------------
// dss_pkg
// Shared widths, reset values and codes of the drum step sequencer.
// ----------------------------------------------------------------------------
package dss_pkg;

    // Fixed port widths
    localparam int FUNC_W      = 2;
    localparam int STEP_IDX_W  = 5;
    localparam int VOICE_W     = 3;
    localparam int PATTERN_W   = 6;
    localparam int TRIG_W      = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_W     = 16;
    localparam int LEN_CFG_W   = 6;

    // Parameter defaults
    localparam int STEPS_DEF   = 32;
    localparam int VOICES_DEF  = 6;

    // Register reset values
    localparam logic [COUNT_W-1:0]   SPT_RESET = 16'd4410;
    localparam logic                 RUN_RESET = 1'b0;
    localparam logic [LEN_CFG_W-1:0] LEN_RESET = 6'd32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN = 2'd2;

    // Item kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_EDIT   = 2'd2
    } func_t;

endpackage

// ----- design/dss_pattern_mem.sv -----
// ----------------------------------------------------------------------------
// dss_pattern_mem
// Pattern store: one voice mask per step, per-bit write mask, registered
// read. Per-entry valid bits stand in for a clear at reset.
// ----------------------------------------------------------------------------
module dss_pattern_mem #(
    parameter int STEPS  = 32,
    parameter int VOICES = 6,
    parameter int IDX_W  = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [VOICES-1:0] wr_mask,
    input  logic [VOICES-1:0] wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [VOICES-1:0] rd_data
);

    logic [VOICES-1:0] mem [STEPS];
    logic [STEPS-1:0]  vld_reg;
    logic [VOICES-1:0] rdata_reg;
    logic              rvalid_reg;

    // Invalid entry: unmasked bits are written as zero.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                if (!vld_reg[wr_addr] || wr_mask[v])
                begin
                    mem[wr_addr][v] <= wr_data[v] & wr_mask[v];
                end
            end
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

// ----- design/drum_step_sequencer.sv -----
// ----------------------------------------------------------------------------
// drum_step_sequencer
// Drum machine step sequencer with a sample-rate tempo divider.
// ----------------------------------------------------------------------------
// Each input transaction is one of: a sample tick (func FUNC_SAMPLE), a full
// step write (FUNC_WRITE) or a single voice edit (FUNC_EDIT); every one
// produces exactly one output transaction. Sample ticks count up to
// samples_per_tick; on reaching it the count drops by that period and, when
// run_enable is set and pattern_length is nonzero, the current step (wrapped
// to 0 at the length) is played: fired=1, played_step and its voice mask on
// triggers. All other results are all zero. One transaction is taken per
// clock while in_stall is low; a result passes through stage A, which
// updates the state and reads the pattern store, and then the output
// register. A spare stage in front of the output register keeps input
// flowing for one more transaction while a result waits on out_stall. The
// pattern store is a single-write, single-read memory with per-step valid
// bits, so it reads as all zeros right after reset with no clearing pass.
// Configuration must be written through cfg_we/cfg_index/cfg_data only
// while no transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module drum_step_sequencer import dss_pkg::*; #(
    parameter int STEPS  = STEPS_DEF,
    parameter int VOICES = VOICES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [FUNC_W-1:0]     func,
    input  logic [STEP_IDX_W-1:0] step_index,
    input  logic [VOICE_W-1:0]    voice,
    input  logic                  pressed,
    input  logic [PATTERN_W-1:0]  pattern_value,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  fired,
    output logic [STEP_IDX_W-1:0] played_step,
    output logic [TRIG_W-1:0]     triggers
);

    localparam int IDX_W = $clog2(STEPS);
    localparam int LEN_W = $clog2(STEPS + 1);

    // Configuration registers
    logic [COUNT_W-1:0]   spt_reg,  spt_next;
    logic                 run_reg,  run_next;
    logic [LEN_CFG_W-1:0] len_reg,  len_next;

    // Sequencer state
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [LEN_W-1:0]     pos_reg,   pos_next;

    // Stage A: state updated, store read in flight
    logic                 a_valid_reg, a_valid_next;
    logic                 a_fired_reg;
    logic [IDX_W-1:0]     a_played_reg;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic                  fired_reg;
    logic [STEP_IDX_W-1:0] played_reg;
    logic [TRIG_W-1:0]     trig_reg;

    // Handshake
    logic accept;
    logic a_move;

    // Datapath
    logic [LEN_W-1:0]     len_eff;
    logic [COUNT_W:0]     cnt_inc;
    logic [COUNT_W:0]     cnt_wrap;
    logic                 tick;
    logic [LEN_W-1:0]     play_pos;
    logic                 fire;
    logic [VOICES-1:0]    vbit;
    logic                 idx_in_store;
    logic                 idx_in_len;
    logic                 voice_ok;

    // Store ports
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [VOICES-1:0]    wr_mask;
    logic [VOICES-1:0]    wr_data;
    logic [IDX_W-1:0]     rd_addr;
    logic [VOICES-1:0]    rd_data;

    // Stage A drains into the output register when it is empty or being taken;
    // input stalls only when stage A is full and cannot drain.
    assign a_move   = a_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = a_valid_reg && !a_move;
    assign accept   = in_valid && !in_stall;

    // Lengths above the store size act as the full store.
    always_comb
    begin
        if (int'(len_reg) > STEPS)
        begin
            len_eff = LEN_W'(STEPS);
        end
        else
        begin
            len_eff = LEN_W'(len_reg);
        end
    end

    // Tempo divider: a zero period ticks every sample, count wraps at 16 bits.
    assign cnt_inc  = {1'b0, count_reg} + {{COUNT_W{1'b0}}, 1'b1};
    assign tick     = cnt_inc >= {1'b0, spt_reg};
    assign cnt_wrap = tick ? (cnt_inc - {1'b0, spt_reg}) : cnt_inc;

    // Position at or past the length restarts at step 0.
    assign play_pos = (pos_reg >= len_eff) ? '0 : pos_reg;
    assign rd_addr  = IDX_W'(play_pos);

    assign idx_in_store = int'(step_index) < STEPS;
    assign idx_in_len   = int'(step_index) < int'(len_eff);
    assign voice_ok     = int'(voice) < VOICES;
    assign vbit         = VOICES'(1) << voice;
    assign wr_addr      = IDX_W'(step_index);

    always_comb
    begin
        fire       = 1'b0;
        count_next = count_reg;
        pos_next   = pos_reg;
        wr_en      = 1'b0;
        wr_mask    = '1;
        wr_data    = VOICES'(pattern_value);
        if (accept)
        begin
            case (func_t'(func))
                FUNC_SAMPLE:
                begin
                    count_next = cnt_wrap[COUNT_W-1:0];
                    fire       = tick && run_reg && (len_eff != '0);
                    if (fire)
                    begin
                        pos_next = play_pos + LEN_W'(1);
                    end
                end
                FUNC_WRITE:
                begin
                    wr_en = idx_in_store;
                end
                FUNC_EDIT:
                begin
                    // Plain set or clear of one voice bit.
                    wr_en   = idx_in_len && voice_ok;
                    wr_mask = vbit;
                    wr_data = pressed ? vbit : '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Configuration writes
    always_comb
    begin
        spt_next = spt_reg;
        run_next = run_reg;
        len_next = len_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPT: spt_next = cfg_data[COUNT_W-1:0];
                CFG_RUN: run_next = cfg_data[0];
                CFG_LEN: len_next = cfg_data[LEN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (a_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg       <= SPT_RESET;
            run_reg       <= RUN_RESET;
            len_reg       <= LEN_RESET;
            count_reg     <= '0;
            pos_reg       <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            spt_reg       <= spt_next;
            run_reg       <= run_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_fired_reg  <= fire;
            a_played_reg <= fire ? rd_addr : '0;
        end
        if (a_move)
        begin
            fired_reg  <= a_fired_reg;
            played_reg <= STEP_IDX_W'(a_played_reg);
            trig_reg   <= a_fired_reg ? TRIG_W'(rd_data) : '0;
        end
    end

    dss_pattern_mem #(
        .STEPS  (STEPS),
        .VOICES (VOICES),
        .IDX_W  (IDX_W)
    ) u_pattern_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_mask (wr_mask),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid   = out_valid_reg;
    assign fired       = fired_reg;
    assign played_step = played_reg;
    assign triggers    = trig_reg;

endmodule

// ----- design/dss_checker.sv -----
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks of the drum step sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module dss_checker import dss_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic [FUNC_W-1:0]     func,
    input logic [STEP_IDX_W-1:0] step_index,
    input logic [VOICE_W-1:0]    voice,
    input logic                  pressed,
    input logic [PATTERN_W-1:0]  pattern_value,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  fired,
    input logic [STEP_IDX_W-1:0] played_step,
    input logic [TRIG_W-1:0]     triggers
);

    // A result that did not fire carries no step and no triggers.
    a_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired |-> played_step == '0 && triggers == '0)
        else $error("non-firing result has nonzero step or triggers");

    // The spare stage means input only stalls behind a stalled result.
    a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid &&
            $stable(fired) && $stable(played_step) && $stable(triggers))
        else $error("output transaction changed while stalled");

    // A stalled input transaction stays put.
    a_in_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(func) && $stable(step_index) &&
            $stable(voice) && $stable(pressed) && $stable(pattern_value))
        else $error("input transaction changed while stalled");

    // Register writes only land on an idle block.
    a_cfg_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !in_valid && !out_valid && !$isunknown({cfg_index, cfg_data}))
        else $error("register write while a transaction is in flight");

endmodule

bind drum_step_sequencer dss_checker u_dss_checker (.*);

// ----- verif/tb_drum_step_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_drum_step_sequencer
// Self-checking regression for the drum step sequencer.
// ----------------------------------------------------------------------------
// A short table of hand-picked transactions comes first, then random traffic
// under a series of tempo, run and length settings. A behavioral copy of the
// sequencer runs beside the block. It predicts every result and queues it, and
// each result leaving the block is checked against the oldest entry. Both
// channels idle at random, except over one long calm stretch.
// ----------------------------------------------------------------------------
module tb_drum_step_sequencer;
    import dss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // func code the block must ignore; it has no member in func_t
    localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [STEP_IDX_W-1:0] step_index;
        logic [VOICE_W-1:0]    voice;
        logic                  pressed;
        logic [PATTERN_W-1:0]  pattern_value;
    } pad_item_t;

    typedef struct packed {
        logic                  fired;
        logic [STEP_IDX_W-1:0] played_step;
        logic [TRIG_W-1:0]     triggers;
    } trig_res_t;

    // One row of the directed table. When has_res is set, res is the result
    // worked out by hand; otherwise the behavioral copy supplies it.
    typedef struct packed {
        pad_item_t it;
        logic      has_res;
        trig_res_t res;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [FUNC_W-1:0]     func;
    logic [STEP_IDX_W-1:0] step_index;
    logic [VOICE_W-1:0]    voice;
    logic                  pressed;
    logic [PATTERN_W-1:0]  pattern_value;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  fired;
    logic [STEP_IDX_W-1:0] played_step;
    logic [TRIG_W-1:0]     triggers;

    drum_step_sequencer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .step_index    (step_index),
        .voice         (voice),
        .pressed       (pressed),
        .pattern_value (pattern_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fired         (fired),
        .played_step   (played_step),
        .triggers      (triggers)
    );

    // ------------------------------------------------------------------
    // Behavioral copy of the sequencer: pattern memory, play position,
    // sample counter, and the register values last written.
    // ------------------------------------------------------------------
    logic [PATTERN_W-1:0] pattern_mem [STEPS_DEF];
    int unsigned          play_pos;
    logic [COUNT_W-1:0]   tick_count;
    logic [COUNT_W-1:0]   cur_spt;
    logic                 cur_run;
    logic [LEN_CFG_W-1:0] cur_len;

    // Expected results, oldest first
    trig_res_t pending_triggers [$];

    int errors = 0;
    int sent_count;
    int steps_played = 0;
    int settings_count;
    int cycles = 0;
    logic calm;

    // One long stretch with no idling on either channel
    assign calm = (sent_count >= 450) && (sent_count < 650);

    // A length above the store size counts as the full store
    function automatic int unsigned live_length();
        return (cur_len > STEPS_DEF) ? STEPS_DEF : cur_len;
    endfunction

    // Apply one transaction to the behavioral copy and return its result
    function automatic trig_res_t advance_sequencer(input pad_item_t it);
        trig_res_t     r;
        logic [16:0]   c;
        int unsigned   len;
        r   = '0;
        len = live_length();
        case (it.func)
            FUNC_SAMPLE:
            begin
                // 17 bits, so a zero period wraps the counter at 16 bits
                c = {1'b0, tick_count} + 17'd1;
                if (c >= {1'b0, cur_spt})
                begin
                    // subtract once only, even when the counter sits far above
                    c = c - {1'b0, cur_spt};
                    if (cur_run && len != 0)
                    begin
                        if (play_pos >= len)
                            play_pos = 0;
                        r.fired       = 1'b1;
                        r.played_step = play_pos[STEP_IDX_W-1:0];
                        r.triggers    = pattern_mem[play_pos];
                        play_pos++;
                    end
                end
                tick_count = c[COUNT_W-1:0];
            end
            FUNC_WRITE:
                // any step of the store, also past the length
                pattern_mem[it.step_index] = it.pattern_value;
            FUNC_EDIT:
                // plain set or clear; outside the length or voices: ignored
                if (it.step_index < len && it.voice < VOICES_DEF)
                    pattern_mem[it.step_index][it.voice] = it.pressed;
            default:
                ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table, run under tick period 1, running, length 4
    // ------------------------------------------------------------------
    plan_row_t plan [21] = '{
        // first tick after reset plays step 0 of an empty store
        '{'{FUNC_SAMPLE,  5'd0,  3'd0, 1'b0, 6'h00}, 1'b1, '{1'b1, 5'd0, 6'h00}},
        '{'{FUNC_WRITE,   5'd0,  3'd0, 1'b0, 6'h3F}, 1'b1, '{1'b0, 5'd0, 6'h00}},
        // write beyond the length is still taken
        '{'{FUNC_WRITE,   5'd31, 3'd0, 1'b0, 6'h2A}, 1'b1, '{1'b0, 5'd0, 6'h00}},
        '{'{FUNC_EDIT,    5'd1,  3'd5, 1'b1, 6'h00}, 1'b1, '{1'b0, 5'd0, 6'h00}},
        '{'{FUNC_EDIT,    5'd1,  3'd0, 1'b1, 6'h00}, 1'b1, '{1'b0, 5'd0, 6'h00}},
        // clear twice: must stay clear, not toggle back
        '{'{FUNC_EDIT,    5'd1,  3'd5, 1'b0, 6'h00}, 1'b1, '{1'b0, 5'd0, 6'h00}},
        '{'{FUNC_EDIT,    5'd1,  3'd5, 1'b0, 6'h00}, 1'b1, '{1'b0, 5'd0, 6'h00}},
        // voices past the top voice, step past the length: ignored
        '{'{FUNC_EDIT,    5'd2,  3'd6, 1'b1, 6'h00}, 1'b1, '{1'b0, 5'd0, 6'h00}},
        '{'{FUNC_EDIT,    5'd2,  3'd7, 1'b1, 6'h00}, 1'b1, '{1'b0, 5'd0, 6'h00}},
        '{'{FUNC_EDIT,    5'd4,  3'd0, 1'b1, 6'h00}, 1'b1, '{1'b0, 5'd0, 6'h00}},
        '{'{FUNC_EDIT,    5'd31, 3'd3, 1'b1, 6'h00}, 1'b1, '{1'b0, 5'd0, 6'h00}},
        // unused func with every other bit high
        '{'{FUNC_IGNORED, 5'd31, 3'd7, 1'b1, 6'h3F}, 1'b1, '{1'b0, 5'd0, 6'h00}},
        '{'{FUNC_SAMPLE,  5'd0,  3'd0, 1'b0, 6'h00}, 1'b1, '{1'b1, 5'd1, 6'h01}},
        '{'{FUNC_SAMPLE,  5'd0,  3'd0, 1'b0, 6'h00}, 1'b1, '{1'b1, 5'd2, 6'h00}},
        '{'{FUNC_SAMPLE,  5'd0,  3'd0, 1'b0, 6'h00}, 1'b1, '{1'b1, 5'd3, 6'h00}},
        // wrap at the length back to step 0
        '{'{FUNC_SAMPLE,  5'd0,  3'd0, 1'b0, 6'h00}, 1'b1, '{1'b1, 5'd0, 6'h3F}},
        '{'{FUNC_WRITE,   5'd2,  3'd0, 1'b0, 6'h15}, 1'b1, '{1'b0, 5'd0, 6'h00}},
        '{'{FUNC_EDIT,    5'd3,  3'd2, 1'b1, 6'h00}, 1'b1, '{1'b0, 5'd0, 6'h00}},
        '{'{FUNC_SAMPLE,  5'd0,  3'd0, 1'b0, 6'h00}, 1'b0, '0},
        '{'{FUNC_SAMPLE,  5'd0,  3'd0, 1'b0, 6'h00}, 1'b0, '0},
        '{'{FUNC_SAMPLE,  5'd0,  3'd0, 1'b0, 6'h00}, 1'b0, '0}
    };

    // Random phases: tick period, run, length, transactions.
    // The last phase draws its own period and length.
    localparam int PHASES = 9;
    logic [COUNT_W-1:0]   ph_spt [PHASES] = '{16'd3, 16'd1, 16'd0, 16'd65535, 16'd2,
                                              16'd4, 16'd2, 16'd1, 16'd5};
    logic                 ph_run [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                              1'b0, 1'b1, 1'b1, 1'b1};
    logic [LEN_CFG_W-1:0] ph_len [PHASES] = '{6'd32, 6'd5, 6'd63, 6'd16, 6'd16,
                                              6'd8, 6'd0, 6'd1, 6'd20};
    int                   ph_cnt [PHASES] = '{150, 120, 120, 120, 100,
                                              100, 80, 80, 160};

    // ------------------------------------------------------------------
    // Clock and cycle watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("drum_step_sequencer regression: fail");
            $finish;
        end
    end

    // Result side: stall at random, about 11 percent of the time, never during the calm stretch
    always @(posedge clk)
        out_stall <= rst_n && !calm && ($urandom_range(99) < 11);

    // ------------------------------------------------------------------
    // Result checker. Sampled at the falling edge: out_stall is driven at the
    // rising edge, so the value seen here is the one the next edge uses.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : check_results
        trig_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_triggers.size() == 0)
            begin
                $error("result with nothing outstanding: fired=%0b step=%0d trig=%02h",
                       fired, played_step, triggers);
                errors++;
            end
            else
            begin
                want = pending_triggers.pop_front();
                if (fired !== want.fired)
                begin
                    $error("fired: expected %0b, got %0b", want.fired, fired);
                    errors++;
                end
                if (played_step !== want.played_step)
                begin
                    $error("played_step: expected %0d, got %0d", want.played_step, played_step);
                    errors++;
                end
                if (triggers !== want.triggers)
                begin
                    $error("triggers: expected %02h, got %02h", want.triggers, triggers);
                    errors++;
                end
                if (want.fired)
                    steps_played++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // Send one transaction. Called at a rising edge; returns at the edge that
    // took it, with in_valid still high so back-to-back traffic needs no
    // drop of valid within one step.
    task automatic send_item(input pad_item_t it, input logic has_res, input trig_res_t res);
        logic      stalled;
        trig_res_t got;
        if (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (!calm && $urandom_range(99) < 11);
        end
        in_valid      <= 1'b1;
        func          <= it.func;
        step_index    <= it.step_index;
        voice         <= it.voice;
        pressed       <= it.pressed;
        pattern_value <= it.pattern_value;
        // in_stall is looked at mid-cycle, settled, for the edge that follows
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        got = advance_sequencer(it);
        pending_triggers = {pending_triggers, (has_res ? res : got)};
        sent_count++;
    endtask

    // Hold off new traffic until every outstanding result is back, then
    // wait on for the pipeline to empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_triggers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all three registers on an idle block
    task automatic apply_settings(input logic [COUNT_W-1:0] spt, input logic run,
                                  input logic [LEN_CFG_W-1:0] len);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPT;
        cfg_data  <= spt;
        @(posedge clk);
        cfg_index <= CFG_RUN;
        cfg_data  <= CFG_DATA_W'(run);
        @(posedge clk);
        cfg_index <= CFG_LEN;
        cfg_data  <= CFG_DATA_W'(len);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_spt = spt;
        cur_run = run;
        cur_len = len;
        settings_count++;
    endtask

    // Mostly ticks, full writes and in-range edits, so patterns fill and steps play;
    // the rest is out-of-range edits and the unused func
    function automatic pad_item_t random_item();
        pad_item_t   it;
        int unsigned pick;
        int unsigned len;
        len  = live_length();
        pick = $urandom_range(99);
        if (pick < 50)
            it.func = FUNC_SAMPLE;
        else if (pick < 70)
            it.func = FUNC_WRITE;
        else if (pick < 95)
            it.func = FUNC_EDIT;
        else
            it.func = FUNC_IGNORED;
        if (len != 0 && $urandom_range(99) < 80)
            it.step_index = STEP_IDX_W'($urandom_range(len - 1));
        else
            it.step_index = STEP_IDX_W'($urandom_range(STEPS_DEF - 1));
        if ($urandom_range(9) == 0)
            it.voice = VOICE_W'($urandom_range(7));
        else
            it.voice = VOICE_W'($urandom_range(VOICES_DEF - 1));
        it.pressed       = 1'($urandom_range(1));
        it.pattern_value = PATTERN_W'($urandom);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sent_count     = 0;
        settings_count = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_SPT;
        cfg_data       = '0;
        in_valid       = 1'b0;
        func           = FUNC_SAMPLE;
        step_index     = '0;
        voice          = '0;
        pressed        = 1'b0;
        pattern_value  = '0;
        foreach (pattern_mem[i])
            pattern_mem[i] = '0;
        play_pos   = 0;
        tick_count = '0;
        cur_spt    = SPT_RESET;
        cur_run    = RUN_RESET;
        cur_len    = LEN_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: one tick per sample, four steps in use
        apply_settings(16'd1, 1'b1, 6'd4);
        foreach (plan[r])
            send_item(plan[r].it, plan[r].has_res, plan[r].res);

        // Random phases; includes zero period, length past the store,
        // stopped and empty patterns, and a counter left above a short period
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES - 1)
                apply_settings(COUNT_W'($urandom_range(6, 1)), 1'b1,
                               LEN_CFG_W'($urandom_range(32, 1)));
            else
                apply_settings(ph_spt[ph], ph_run[ph], ph_len[ph]);
            for (int k = 0; k < ph_cnt[ph]; k++)
            begin
                // one mid-phase pause until the block has drained
                if (ph == 0 && k == ph_cnt[ph] / 2)
                    settle();
                send_item(random_item(), 1'b0, '0);
            end
        end

        settle();
        repeat (10) @(posedge clk);

        $display("Sent %0d transactions across %0d register settings;",
                 sent_count, settings_count);
        $display("%0d steps played, %0d mismatches.", steps_played, errors);
        if (errors == 0)
            $display("drum_step_sequencer regression: pass");
        else
            $display("drum_step_sequencer regression: fail");
        $finish;
    end

endmodule
